[hdl/f2q_pkg.sv]
// ----------------------------------------------------------------------------
// f2q_pkg
// Shared constants and stage payload types for the float to int8 quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
package f2q_pkg;
  localparam int unsigned SampleW = 32;
  localparam int unsigned QuantW  = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegRecipScale = 2'd0;
  localparam logic [CfgIdxW-1:0] RegZeroPoint  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSignedMode = 2'd2;

  localparam logic [31:0] RecipScaleReset = 32'h3F80_0000;

  localparam logic signed [QuantW-1:0] QminSigned   = -9'sd128;
  localparam logic signed [QuantW-1:0] QmaxSigned   = 9'sd127;
  localparam logic signed [QuantW-1:0] QminUnsigned = 9'sd0;
  localparam logic signed [QuantW-1:0] QmaxUnsigned = 9'sd255;

  // Stage 1 to 2: raw mantissa product and exponent sum
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;   // unbiased exponent of the product of 1.x forms
    logic [47:0] prod;         // 24x24 mantissa product
  } f2q_mul_t;

  // Stage 2 to 3: product rounded to float32 (nearest even), then to an integer
  typedef struct packed {
    logic        nan;
    logic        big;         // magnitude >= 1024
    logic        sign;
    logic [10:0] mag;         // |round_half_away(p)|, at most 1024
  } f2q_rnd_t;
endpackage
`default_nettype wire

[hdl/f2q_mul.sv]
// ----------------------------------------------------------------------------
// f2q_mul
// Stage 1: unpack both operands, normalize subnormals, multiply mantissas.
// ----------------------------------------------------------------------------
`default_nettype none
module f2q_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output f2q_pkg::f2q_mul_t res_r
);
  f2q_pkg::f2q_mul_t res_nxt;
  logic [23:0] ma, mb, na, nb;
  logic [4:0]  lza, lzb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  // Count leading zeros of a 24-bit mantissa
  function automatic logic [4:0] f2q_lz(input logic [23:0] m);
    logic [4:0] n;
    logic       hit;
    n = 5'd0;
    hit = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!hit && m[i]) begin
        hit = 1'b1;
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

  // Unpack and normalize
  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    ma = {(a[30:23] != 8'h00), a[22:0]};
    mb = {(b[30:23] != 8'h00), b[22:0]};
    lza = f2q_lz(ma);
    lzb = f2q_lz(mb);
    na = ma << lza;
    nb = mb << lzb;
    res_nxt.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    res_nxt.inf  = a_inf || b_inf;
    res_nxt.zero = a_zero || b_zero;
    res_nxt.sign = a[31] ^ b[31];
    res_nxt.exp  = 11'(signed'({3'b0, (a[30:23] == 8'h00) ? 8'd1 : a[30:23]}))
                 + 11'(signed'({3'b0, (b[30:23] == 8'h00) ? 8'd1 : b[30:23]}))
                 - 11'sd254 - 11'(signed'({6'b0, lza})) - 11'(signed'({6'b0, lzb}));
    res_nxt.prod = 48'(na) * 48'(nb);
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/f2q_rnd.sv]
// ----------------------------------------------------------------------------
// f2q_rnd
// Stage 2: round the product to float32 (nearest even, with subnormals),
// then round that value to an integer with halves away from zero.
// ----------------------------------------------------------------------------
`default_nettype none
module f2q_rnd (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire f2q_pkg::f2q_mul_t m,
  output f2q_pkg::f2q_rnd_t      res_r
);
  f2q_pkg::f2q_rnd_t res_nxt;
  logic [47:0] pn;
  logic signed [11:0] e;        // exponent of leading bit
  logic [6:0]  sh;
  logic [49:0] wide;            // 24-bit significand + guard + sticky region
  logic [23:0] sig;
  logic        g, st, up;
  logic [24:0] sigr;
  logic signed [11:0] er;
  logic [35:0] fx;              // value scaled by 2^25 below 1024
  logic [10:0] ip;

  always_comb begin
    // normalize so bit 47 is the leading one
    pn = m.prod[47] ? m.prod : {m.prod[46:0], 1'b0};
    e  = 12'(m.exp) + (m.prod[47] ? 12'sd1 : 12'sd0);
    // subnormal result: shift right by (-126 - e)
    if (e < -12'sd126) begin
      sh = ((-12'sd126 - e) > 12'sd49) ? 7'd49 : 7'((-12'sd126 - e));
    end else begin
      sh = 7'd0;
    end
    wide = {pn, 2'b00} >> sh;
    st   = (({pn, 2'b00} & ~({pn, 2'b00} >> sh << sh)) != '0);
    sig  = wide[49:26];
    g    = wide[25];
    st   = st || (wide[24:0] != '0);
    up   = g && (st || sig[0]);
    sigr = {1'b0, sig} + 25'(up);
    er   = (e < -12'sd126) ? -12'sd126 : e;
    // carry out of the significand: renormalize
    if (sigr[24]) begin
      er   = er + 12'sd1;
      sigr = sigr >> 1;
    end
    // value = sigr * 2^(er-23)
    res_nxt.nan  = m.nan;
    res_nxt.sign = m.sign;
    res_nxt.big  = !m.nan && (m.inf || (!m.zero && er >= 12'sd10));
    fx = '0;
    if (!m.zero && !m.inf && er < 12'sd10 && er >= -12'sd2) begin
      // fx = value * 2^25: bit 25 weighs 1, bit 24 one half
      fx = 36'(sigr) << 4'(er + 12'sd2);
    end
    ip = fx[35:25] + 11'(fx[24]);
    res_nxt.mag = m.zero ? 11'd0 : ip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/f2q_sat.sv]
// ----------------------------------------------------------------------------
// f2q_sat
// Stage 3: add the zero point and saturate to the byte range of the mode.
// ----------------------------------------------------------------------------
`default_nettype none
module f2q_sat (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire f2q_pkg::f2q_rnd_t      r,
  input  wire logic signed [8:0]      zero_point,
  input  wire logic                   signed_mode,
  output logic signed [8:0]           quantized_r,
  output logic                        clipped_r
);
  logic signed [12:0] y;
  logic signed [12:0] lo, hi;
  logic signed [8:0]  q_nxt;
  logic               c_nxt;

  always_comb begin
    lo = signed_mode ? 13'(f2q_pkg::QminSigned) : 13'(f2q_pkg::QminUnsigned);
    hi = signed_mode ? 13'(f2q_pkg::QmaxSigned) : 13'(f2q_pkg::QmaxUnsigned);
    priority if (r.nan) begin
      y = 13'(zero_point);
    end else if (r.big) begin
      y = r.sign ? lo - 13'sd1 : hi + 13'sd1;
    end else begin
      y = (r.sign ? -13'(signed'({2'b0, r.mag})) : 13'(signed'({2'b0, r.mag})))
        + 13'(zero_point);
    end
    priority if (y > hi) begin
      q_nxt = 9'(hi);
      c_nxt = 1'b1;
    end else if (y < lo) begin
      q_nxt = 9'(lo);
      c_nxt = 1'b1;
    end else begin
      q_nxt = 9'(y);
      c_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quantized_r <= q_nxt;
      clipped_r   <= c_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/float_to_int8_quantizer_core.sv]
// ----------------------------------------------------------------------------
// float_to_int8_quantizer_core: float32 sample to signed/unsigned byte
// Pipeline: three registered stages from input request to result (multiply, round, saturate).
// Throughput: one sample per cycle; all stages hold while the last stage
// holds a request and out_stall is high, and in_stall is high exactly then.
// Reset (synchronous, rst_n low) clears valid bits, loads scale 1.0, zp 0, signed.
// ----------------------------------------------------------------------------
`default_nettype none
module float_to_int8_quantizer_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       in_sample_bits,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [8:0]      out_quantized,
  output logic                   out_clipped,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  logic [31:0]       recip_scale_r;
  logic signed [8:0] zero_point_r;
  logic              signed_mode_r;
  logic [2:0]        vld_r;
  logic              adv;
  f2q_pkg::f2q_mul_t mul_r;
  f2q_pkg::f2q_rnd_t rnd_r;

  // Advance the whole pipe unless the last stage holds a stalled request
  assign adv      = !(vld_r[2] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_scale_r <= f2q_pkg::RecipScaleReset;
      zero_point_r  <= '0;
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        f2q_pkg::RegRecipScale: recip_scale_r <= cfg_data;
        f2q_pkg::RegZeroPoint:  zero_point_r  <= cfg_data[8:0];
        f2q_pkg::RegSignedMode: signed_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  f2q_mul u_mul (
    .clk(clk), .en(adv), .a(in_sample_bits), .b(recip_scale_r), .res_r(mul_r)
  );
  f2q_rnd u_rnd (.clk(clk), .en(adv), .m(mul_r), .res_r(rnd_r));
  f2q_sat u_sat (
    .clk(clk), .en(adv), .r(rnd_r), .zero_point(zero_point_r),
    .signed_mode(signed_mode_r), .quantized_r(out_quantized),
    .clipped_r(out_clipped)
  );
endmodule
`default_nettype wire
